// ===== design/sba_pkg.sv =====
package sba_pkg;

    localparam int unsigned HEADER_BYTES      = 8;
    localparam int unsigned HEADER_ALIGN      = 8;
    localparam int unsigned HEADER_ALIGN_LOG2 = 3;
    localparam int unsigned MAX_ALIGN         = 4096;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_GROW   = 3'd1,
        OP_SHRINK = 3'd2,
        OP_FREE   = 3'd3,
        OP_RESET  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOMEM   = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        old_present;
        logic [15:0] block_offset;
        logic [16:0] old_length;
        logic [16:0] new_size;
        logic [12:0] alignment;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] result_offset;
        logic [16:0] result_length;
        logic        copy_needed;
        logic [16:0] copy_length;
        logic [16:0] fill_level;
    } t_rsp;

endpackage

// ===== design/stack_buffer_allocator.sv =====
// Stack allocator over a buffer of up to BUFFER_BYTES bytes, with a header slot before each
// block that keeps the fill level from before the push. One request is taken per cycle while
// the output is not stalled, and its result is presented behind a request register and a
// result register. A free reads the header memory: the read is issued as the request is
// taken, so the data is ready in the next cycle, with a same-cycle header write forwarded
// past the memory. Writing buffer_length empties the stack; write it only while no request
// is in flight. Copying data between blocks is left to outside logic, as told by copy_needed
// and copy_length.
module stack_buffer_allocator #(
    parameter int unsigned BUFFER_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_buffer_length,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic        i_old_present,
    input  logic [15:0] i_block_offset,
    input  logic [16:0] i_old_length,
    input  logic [16:0] i_new_size,
    input  logic [12:0] i_alignment,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_offset,
    output logic [16:0] o_result_length,
    output logic        o_copy_needed,
    output logic [16:0] o_copy_length,
    output logic [16:0] o_fill_level
);

    localparam int unsigned HDR_DEPTH = BUFFER_BYTES / sba_pkg::HEADER_ALIGN;
    localparam int unsigned ADDR_W    = $clog2(HDR_DEPTH);

    logic              cfg_write;
    logic              in_accept;
    logic              out_free;
    logic              advance;
    logic [16:0]       buf_len;
    logic [ADDR_W-1:0] rd_addr;
    logic [16:0]       ram_rdata;
    logic [16:0]       hdr_level;
    logic              hdr_we;
    logic              core_we;
    logic [ADDR_W-1:0] hdr_addr;
    logic [16:0]       hdr_data;
    logic [16:0]       next_used;
    sba_pkg::t_rsp     core_rsp;
    sba_pkg::t_req     n_req;

    logic [16:0]       r_buffer_length;
    logic [16:0]       r_used;
    logic              r_work_valid;
    sba_pkg::t_req     r_req;
    logic              r_fwd_hit;
    logic [16:0]       r_fwd_data;
    logic              r_out_valid;
    sba_pkg::t_rsp     r_rsp;

    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !r_work_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_work_valid && out_free;
    assign o_in_stall  = r_work_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;

    assign buf_len = ({8'd0, r_buffer_length} < 25'(BUFFER_BYTES))
                   ? r_buffer_length : 17'(BUFFER_BYTES);

    assign n_req.opcode       = i_opcode;
    assign n_req.old_present  = i_old_present;
    assign n_req.block_offset = i_block_offset;
    assign n_req.old_length   = i_old_length;
    assign n_req.new_size     = i_new_size;
    assign n_req.alignment    = i_alignment;

    assign rd_addr = ADDR_W'((i_block_offset - 16'(sba_pkg::HEADER_BYTES))
                            >> sba_pkg::HEADER_ALIGN_LOG2);
    assign hdr_we  = advance && core_we;

    sba_ram #(
        .WIDTH (17),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (hdr_addr),
        .i_wdata (hdr_data),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign hdr_level = r_fwd_hit ? r_fwd_data : ram_rdata;

    sba_core #(
        .ADDR_W (ADDR_W)
    ) u_core (
        .i_req       (r_req),
        .i_used      (r_used),
        .i_buf_len   (buf_len),
        .i_hdr_level (hdr_level),
        .o_rsp       (core_rsp),
        .o_next_used (next_used),
        .o_hdr_we    (core_we),
        .o_hdr_addr  (hdr_addr),
        .o_hdr_data  (hdr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= 17'd0;
            r_used          <= 17'd0;
            r_work_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_buffer_length <= i_buffer_length;
                r_used          <= 17'd0;
            end else if (advance) begin
                r_used <= next_used;
            end
            if (in_accept) begin
                r_work_valid <= 1'b1;
            end else if (advance) begin
                r_work_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request register, header forwarding and result register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req      <= n_req;
            r_fwd_hit  <= hdr_we && (hdr_addr == rd_addr);
            r_fwd_data <= hdr_data;
        end
        if (advance) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_rsp.status;
    assign o_result_offset = r_rsp.result_offset;
    assign o_result_length = r_rsp.result_length;
    assign o_copy_needed   = r_rsp.copy_needed;
    assign o_copy_length   = r_rsp.copy_length;
    assign o_fill_level    = r_rsp.fill_level;

`ifndef SYNTH
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.status != sba_pkg::ST_OK |->
            r_rsp.result_offset == 16'd0 && r_rsp.result_length == 17'd0
            && !r_rsp.copy_needed && r_rsp.copy_length == 17'd0)
        else $error("error result carries data");

    a_copy_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_rsp.copy_needed == (r_rsp.copy_length != 17'd0))
        else $error("copy flag and length disagree");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_work_valid && r_out_valid)
        else $error("input stalled with a free pipeline");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_we |-> next_used > r_used)
        else $error("push did not raise the fill level");

    a_fill_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !cfg_write |=> r_used == r_rsp.fill_level)
        else $error("fill level and reported level differ");
`endif

endmodule

// ===== design/sba_ram.sv =====
module sba_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the contents from before a write in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sba_core.sv =====
module sba_core #(
    parameter int unsigned ADDR_W = 13
) (
    input  sba_pkg::t_req       i_req,
    input  logic [16:0]         i_used,
    input  logic [16:0]         i_buf_len,
    input  logic [16:0]         i_hdr_level,
    output sba_pkg::t_rsp       o_rsp,
    output logic [16:0]         o_next_used,
    output logic                o_hdr_we,
    output logic [ADDR_W-1:0]   o_hdr_addr,
    output logic [16:0]         o_hdr_data
);

    logic [12:0]     align_eff;
    logic            align_bad;
    logic [12:0]     round_to;
    logic [17:0]     start_raw;
    logic [17:0]     start;
    logic [18:0]     alloc_end;
    logic            alloc_fits;
    sba_pkg::t_status alloc_status;
    logic            at_top;
    logic [17:0]     resize_end;
    logic            resize_fits;
    logic [16:0]     copy_min;
    logic            take_alloc;
    logic [16:0]     copy_len;
    logic [16:0]     next_used;

    assign align_eff = (i_req.alignment == 13'd0) ? 13'd1 : i_req.alignment;
    assign align_bad = ((align_eff & (align_eff - 13'd1)) != 13'd0)
                     || ({4'd0, align_eff} > 17'(sba_pkg::MAX_ALIGN));
    assign round_to  = (align_eff > 13'(sba_pkg::HEADER_ALIGN))
                     ? align_eff : 13'(sba_pkg::HEADER_ALIGN);
    assign start_raw = {1'b0, i_used} + 18'(sba_pkg::HEADER_BYTES)
                     + {5'd0, round_to} - 18'd1;
    assign start     = start_raw & ~{5'd0, round_to - 13'd1};
    assign alloc_end = {1'b0, start} + {2'd0, i_req.new_size};
    assign alloc_fits = alloc_end <= {2'd0, i_buf_len};

    always_comb begin
        if (i_req.new_size == 17'd0 || align_bad) begin
            alloc_status = sba_pkg::ST_INVALID;
        end else if (!alloc_fits) begin
            alloc_status = sba_pkg::ST_NOMEM;
        end else begin
            alloc_status = sba_pkg::ST_OK;
        end
    end

    assign at_top = i_req.old_present
                  && ({2'd0, i_req.block_offset} + {1'b0, i_req.old_length}
                      == {1'b0, i_used});
    // at the top the old fill level minus the old length is the block offset
    assign resize_end  = {2'd0, i_req.block_offset} + {1'b0, i_req.new_size};
    assign resize_fits = resize_end <= {1'b0, i_buf_len};
    assign copy_min    = (i_req.new_size < i_req.old_length)
                       ? i_req.new_size : i_req.old_length;

    assign o_hdr_addr = ADDR_W'((start - 18'(sba_pkg::HEADER_BYTES))
                               >> sba_pkg::HEADER_ALIGN_LOG2);
    assign o_hdr_data = i_used;

    always_comb begin
        take_alloc              = 1'b0;
        copy_len                = 17'd0;
        next_used               = i_used;
        o_hdr_we                = 1'b0;
        o_rsp.status            = sba_pkg::ST_OK;
        o_rsp.result_offset     = 16'd0;
        o_rsp.result_length     = 17'd0;
        o_rsp.copy_needed       = 1'b0;
        o_rsp.copy_length       = 17'd0;
        case (i_req.opcode)
            sba_pkg::OP_ALLOC: begin
                take_alloc = 1'b1;
            end
            sba_pkg::OP_GROW: begin
                if (at_top && resize_fits) begin
                    next_used           = resize_end[16:0];
                    o_rsp.result_offset = i_req.block_offset;
                    o_rsp.result_length = i_req.new_size;
                end else begin
                    take_alloc = 1'b1;
                    copy_len   = i_req.old_present ? i_req.old_length : 17'd0;
                end
            end
            sba_pkg::OP_SHRINK: begin
                if (!i_req.old_present) begin
                    o_rsp.status = sba_pkg::ST_INVALID;
                end else if (at_top) begin
                    if (!resize_fits) begin
                        o_rsp.status = sba_pkg::ST_NOMEM;
                    end else begin
                        next_used           = resize_end[16:0];
                        o_rsp.result_offset = i_req.block_offset;
                        o_rsp.result_length = i_req.new_size;
                    end
                end else begin
                    take_alloc = 1'b1;
                    copy_len   = copy_min;
                end
            end
            sba_pkg::OP_FREE: begin
                if (at_top) begin
                    next_used = (i_req.block_offset < 16'(sba_pkg::HEADER_BYTES))
                              ? 17'd0 : i_hdr_level;
                end
            end
            sba_pkg::OP_RESET: begin
                next_used = 17'd0;
            end
            default: begin
                o_rsp.status = sba_pkg::ST_INVALID;
            end
        endcase
        if (take_alloc) begin
            if (alloc_status != sba_pkg::ST_OK) begin
                o_rsp.status = alloc_status;
            end else begin
                o_hdr_we            = 1'b1;
                next_used           = alloc_end[16:0];
                o_rsp.result_offset = start[15:0];
                o_rsp.result_length = i_req.new_size;
                o_rsp.copy_length   = copy_len;
                o_rsp.copy_needed   = copy_len != 17'd0;
            end
        end
        o_rsp.fill_level = next_used;
        o_next_used      = next_used;
    end

endmodule
